/* hdl/rgb_status_led_controller_top_assert.svh */
// assertion macros for the rgb status led controller checker
// expects clk and rst_n to be visible where the macros are used
`ifndef RGB_STATUS_LED_CONTROLLER_TOP_ASSERT_SVH
`define RGB_STATUS_LED_CONTROLLER_TOP_ASSERT_SVH

// checked only out of reset
`define RSL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define RSL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/rsl_pkg.sv */
// types, codes and constants of the rgb status led controller
// no dependencies
package rsl_pkg;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_USER   = 2'd1,
        REQ_STATUS = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        CFG_PWM_PERIOD  = 2'd0,
        CFG_MS_PER_TICK = 2'd1,
        CFG_HOLD_MS     = 2'd2
    } cfg_idx_t;

    localparam logic [2:0] STATUS_SUCCESS      = 3'd0;
    localparam logic [2:0] STATUS_LOCKED       = 3'd1;
    localparam logic [2:0] STATUS_SHUTDOWN     = 3'd2;
    localparam logic [2:0] STATUS_NOT_CHARGING = 3'd3;
    localparam logic [2:0] STATUS_CC           = 3'd4;
    localparam logic [2:0] STATUS_CV           = 3'd5;
    localparam logic [2:0] STATUS_DONE         = 3'd6;

    // floor(x / 255) for 16-bit x is (x * 0x8081) >> 23
    localparam logic [15:0] DIV255_RECIP = 16'h8081;
    localparam int          DIV255_SHIFT = 23;
    localparam int          INC_W        = 9;

    localparam logic [INC_W-1:0] INC_RESET        = 9'd257;
    localparam logic [15:0]      MS_PER_TICK_RESET = 16'd256;
    localparam logic [15:0]      HOLD_MS_RESET     = 16'd300;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    function automatic color_t status_color(input logic [2:0] code);
        color_t c;
        c = '0;
        case (code)
            STATUS_SUCCESS:      c = '{red: 8'd10, green: 8'd10, blue: 8'd10};
            STATUS_LOCKED:       c = '{red: 8'd0,  green: 8'd0,  blue: 8'd20};
            STATUS_SHUTDOWN:     c = '{red: 8'd20, green: 8'd20, blue: 8'd20};
            STATUS_NOT_CHARGING: c = '{red: 8'd10, green: 8'd0,  blue: 8'd10};
            STATUS_CC:           c = '{red: 8'd2,  green: 8'd0,  blue: 8'd0};
            STATUS_CV:           c = '{red: 8'd2,  green: 8'd2,  blue: 8'd0};
            STATUS_DONE:         c = '{red: 8'd0,  green: 8'd2,  blue: 8'd0};
            default:             c = '0;
        endcase
        return c;
    endfunction

endpackage

/* hdl/rgb_status_led_controller_top.sv */
// top level of the rgb status led controller
// depends on rsl_pkg
//
// Takes one word per clock cycle on the input channel while the output is not
// stalled, and produces at most one word of three PWM compare values per input
// word. The stages are the input register, the decision stage (which updates the
// stored user colour, tick, change tick and transient flag) and the duty stage
// (three 8x9 multiplies by the per-step increment). The decision stage is a loop
// through the stored change tick: one 16x16 multiply of the tick difference by
// ms_per_tick_reg (Q8.8), saturate, compare with hold_ms. The increment
// floor(pwm_period / 255) is computed when pwm_period is written, so
// configuration must be written by the user only while the block is idle; the block does not enforce it.
module rgb_status_led_controller_top
    import rsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] tick_now,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [2:0]  status_code,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] duty_red,
    output logic [15:0] duty_green,
    output logic [15:0] duty_blue,
    output logic        is_transient
);

    // configuration
    logic [INC_W-1:0] inc_reg;
    logic [15:0]      ms_per_tick_reg;
    logic [15:0]      hold_ms_reg;
    logic [31:0]      inc_prod;

    // input stage
    logic        s1_valid_reg;
    logic [1:0]  s1_req_reg;
    logic [15:0] s1_tick_reg;
    color_t      s1_color_reg;
    logic [2:0]  s1_status_reg;

    // decision stage
    logic        s2_valid_reg, s2_valid_next;
    color_t      s2_color_reg, s2_color_next;
    logic        s2_trans_reg, s2_trans_next;

    // block state
    logic [15:0] last_tick_reg, last_tick_next;
    logic [15:0] change_tick_reg, change_tick_next;
    logic        trans_active_reg, trans_active_next;
    color_t      user_color_reg, user_color_next;

    // output stage
    logic        out_valid_reg;
    logic [15:0] duty_red_reg, duty_green_reg, duty_blue_reg;
    logic        is_transient_reg;

    logic        out_adv;
    logic        s2_free;
    logic        s1_adv;
    logic        in_take;

    logic [15:0] diff;
    logic [31:0] elapsed_prod;
    logic [15:0] elapsed;
    color_t      stat_color;
    logic [16:0] mul_red, mul_green, mul_blue;

    assign out_adv = !out_valid_reg || out_ready;
    assign s2_free = !s2_valid_reg || out_adv;
    assign s1_adv  = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;
    assign in_take  = in_valid && in_ready;

    assign inc_prod = 32'(cfg_data) * 32'(DIV255_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_reg         <= INC_RESET;
            ms_per_tick_reg <= MS_PER_TICK_RESET;
            hold_ms_reg     <= HOLD_MS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PWM_PERIOD:  inc_reg <= inc_prod[DIV255_SHIFT +: INC_W];
                CFG_MS_PER_TICK: ms_per_tick_reg <= cfg_data;
                CFG_HOLD_MS:     hold_ms_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_req_reg    <= req_type;
            s1_tick_reg   <= tick_now;
            s1_color_reg  <= '{red: red_in, green: green_in, blue: blue_in};
            s1_status_reg <= status_code;
        end
    end

    // elapsed ms since last colour change, Q8.8 product truncated and saturated
    assign diff         = s1_tick_reg - change_tick_reg;
    assign elapsed_prod = 32'(diff) * 32'(ms_per_tick_reg);
    assign elapsed      = (elapsed_prod[31:24] != 8'd0) ? 16'hFFFF : elapsed_prod[23:8];
    assign stat_color   = status_color(s1_status_reg);

    always_comb
    begin
        last_tick_next    = last_tick_reg;
        change_tick_next  = change_tick_reg;
        trans_active_next = trans_active_reg;
        user_color_next   = user_color_reg;
        s2_valid_next     = 1'b0;
        s2_color_next     = user_color_reg;
        s2_trans_next     = 1'b0;

        unique case (req_t'(s1_req_reg))
            REQ_TICK:
            begin
                last_tick_next = s1_tick_reg;
                if (trans_active_reg && (elapsed > hold_ms_reg))
                begin
                    s2_valid_next = 1'b1;
                    s2_color_next = user_color_reg;
                    s2_trans_next = 1'b0;
                end
            end
            REQ_USER:
            begin
                user_color_next = s1_color_reg;
                if (!trans_active_reg)
                begin
                    s2_valid_next = 1'b1;
                    s2_color_next = s1_color_reg;
                    s2_trans_next = 1'b0;
                end
            end
            REQ_STATUS:
            begin
                // unknown status code is dropped
                if (s1_status_reg <= STATUS_DONE)
                begin
                    s2_valid_next = 1'b1;
                    s2_color_next = stat_color;
                    s2_trans_next = (s1_status_reg != STATUS_LOCKED);
                end
            end
            default: ;
        endcase

        // every written colour restarts the hold timer from the latest tick
        if (s2_valid_next)
        begin
            trans_active_next = s2_trans_next;
            change_tick_next  = last_tick_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_tick_reg    <= '0;
            change_tick_reg  <= '0;
            trans_active_reg <= 1'b0;
            user_color_reg   <= '0;
        end
        else if (s1_adv)
        begin
            last_tick_reg    <= last_tick_next;
            change_tick_reg  <= change_tick_next;
            trans_active_reg <= trans_active_next;
            user_color_reg   <= user_color_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_adv && s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_color_reg <= s2_color_next;
            s2_trans_reg <= s2_trans_next;
        end
    end

    // duty = value * floor(period / 255), kept to 16 bits
    assign mul_red   = 17'(s2_color_reg.red) * 17'(inc_reg);
    assign mul_green = 17'(s2_color_reg.green) * 17'(inc_reg);
    assign mul_blue  = 17'(s2_color_reg.blue) * 17'(inc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s2_valid_reg)
        begin
            duty_red_reg     <= mul_red[15:0];
            duty_green_reg   <= mul_green[15:0];
            duty_blue_reg    <= mul_blue[15:0];
            is_transient_reg <= s2_trans_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign duty_red     = duty_red_reg;
    assign duty_green   = duty_green_reg;
    assign duty_blue    = duty_blue_reg;
    assign is_transient = is_transient_reg;

endmodule

/* hdl/rsl_checker.sv */
// port-level checker for the rgb status led controller, bound to the top level
// depends on rgb_status_led_controller_top_assert.svh
`include "rgb_status_led_controller_top_assert.svh"

module rsl_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] duty_red,
    input logic [15:0] duty_green,
    input logic [15:0] duty_blue,
    input logic        is_transient
);

    // a stalled result word holds
    `RSL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(duty_red) && $stable(duty_green) && $stable(duty_blue) && $stable(is_transient), "result word changed while stalled")

    // input backpressure only when the whole pipeline is blocked by the output
    `RSL_ASSERT_ALWAYS(a_ready_backpressure, !in_ready |-> out_valid && !out_ready, "input stalled without output stall")

    // a word needs three stages, so nothing comes out right after reset
    `RSL_ASSERT(a_drain_after_reset, $past(!rst_n, 2) |-> !out_valid, "result word too soon after reset")

endmodule

bind rgb_status_led_controller_top rsl_checker u_rsl_checker (.*);
